[design/lbcf_pkg.sv]
// Shared widths, types and reset constants of the line blur filter.
`timescale 1ns / 1ps
package lbcf_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int WEIGHT_W     = 16;
  localparam int OUT_W        = 16;
  localparam int FRAC_SHIFT   = 8;
  localparam int NUM_WEIGHTS  = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [OUT_W-1:0]    blurred_t;

  localparam weight_t WEIGHT_D0_RESET = '1;
  localparam weight_t WEIGHT_DN_RESET = '0;

  typedef struct packed {
    logic valid;
    logic last;
  } lbcf_ctl_t;

endpackage

[design/lbcf_if.sv]
// Request channels of the line blur filter: samples, results and configuration writes.
`timescale 1ns / 1ps
interface lbcf_in_if;
  logic                      valid;
  logic                      ready;
  logic [lbcf_pkg::SAMPLE_W-1:0] sample;
  logic                      line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink (input valid, input sample, input line_end, output ready);
endinterface

interface lbcf_out_if;
  logic                      valid;
  logic                      ready;
  logic [lbcf_pkg::OUT_W-1:0] blurred;
  logic                      out_last;

  modport source (output valid, output blurred, output out_last, input ready);
  modport sink (input valid, input blurred, input out_last, output ready);
endinterface

interface lbcf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lbcf_pkg::CFG_IDX_W-1:0]  index;
  logic [lbcf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/lbcf_filter.sv]
// Two-stage weighted sum of a sample window: symmetric tap products, then sum and saturation.
`timescale 1ns / 1ps
module lbcf_filter #(
  parameter int MAX_RADIUS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  lbcf_pkg::lbcf_ctl_t win_ctl,
  input  lbcf_pkg::sample_t   window [2*MAX_RADIUS+3],
  input  lbcf_pkg::weight_t   weights [lbcf_pkg::NUM_WEIGHTS],
  output logic                win_ready,
  lbcf_out_if.source          results
);
  import lbcf_pkg::*;

  localparam int DELAY  = MAX_RADIUS + 1;
  localparam int PAIR_W = SAMPLE_W + 1;
  localparam int PROD_W = WEIGHT_W + PAIR_W;
  localparam int ACC_W  = PROD_W + $clog2(DELAY + 1);

  logic [PROD_W-1:0] prod [DELAY+1];
  lbcf_ctl_t         prod_ctl;
  logic              prod_ready;
  logic              out_ready;
  logic [ACC_W-1:0]  acc;
  blurred_t          blurred_next;
  logic              out_valid;
  blurred_t          blurred;
  logic              out_last;

  assign out_ready  = !out_valid || results.ready;
  assign prod_ready = !prod_ctl.valid || out_ready;
  assign win_ready  = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else if (prod_ready) begin
      prod_ctl <= win_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready) begin
      prod[0] <= PROD_W'(weights[0]) * PROD_W'(window[DELAY]);
      for (int d = 1; d <= DELAY; d++) begin
        prod[d] <= PROD_W'(weights[d]) *
                   PROD_W'(PAIR_W'(window[DELAY-d]) + PAIR_W'(window[DELAY+d]));
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int d = 0; d <= DELAY; d++) begin
      acc = acc + ACC_W'(prod[d]);
    end
    if (|acc[ACC_W-1:FRAC_SHIFT+OUT_W]) begin
      blurred_next = '1;
    end else begin
      blurred_next = acc[FRAC_SHIFT+OUT_W-1:FRAC_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= prod_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      blurred  <= blurred_next;
      out_last <= prod_ctl.last;
    end
  end

  assign results.valid    = out_valid;
  assign results.blurred  = blurred;
  assign results.out_last = out_last;

endmodule

[design/line_blur_clamped_fir.sv]
// Top level of the scan line blur filter: sample window, line position and flush control.
//
// Usage: samples enter on the samples channel, one grey level per request, with
// line_end set on the final sample of a line. Filtered Q8.8 values leave on the
// results channel, with out_last set on the final value of the line. Weights per
// tap distance are written on the cfg channel, index 0 to 5, while the block is idle.
// A result belongs to the sample MAX_RADIUS+1 positions back; after the request that
// completes its window it passes the window, product and sum registers in turn.
// Throughput is one sample per cycle inside a line while results.ready is high. A
// request with line_end set shifts the last sample in MAX_RADIUS+1 more times, one
// per cycle unless stalled, and samples.ready stays low while the flush results drain.
// When results.ready is low, the output register holds its value and the earlier
// stages keep filling until every stage holds a result, then samples.ready drops.
// Reset sets weight 0 to 65535 and the others to zero, returns the line position
// to the start of a line and empties the pipeline.
`timescale 1ns / 1ps
module line_blur_clamped_fir #(
  parameter int MAX_RADIUS = 4
) (
  input  logic       clk,
  input  logic       rst,
  lbcf_in_if.sink    samples,
  lbcf_out_if.source results,
  lbcf_cfg_if.sink   cfg
);
  import lbcf_pkg::*;

  localparam int DELAY = MAX_RADIUS + 1;
  localparam int TAPS  = 2 * MAX_RADIUS + 3;
  localparam int POS_W = $clog2(DELAY + 2);
  localparam int FL_W  = $clog2(DELAY + 1);

  weight_t          weights [NUM_WEIGHTS];
  sample_t          window [TAPS];
  sample_t          window_next [TAPS];
  logic [POS_W-1:0] line_pos;
  logic [POS_W-1:0] line_pos_next;
  logic [POS_W-1:0] pos_inc;
  logic [FL_W-1:0]  flush_cnt;
  logic [FL_W-1:0]  flush_cnt_next;
  lbcf_ctl_t        win_ctl;
  lbcf_ctl_t        win_ctl_next;
  logic             win_ready;
  logic             win_adv;
  logic             accept;
  logic             step;
  logic             load;
  logic             fill;
  sample_t          shift_in;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights[0] <= WEIGHT_D0_RESET;
      for (int i = 1; i < NUM_WEIGHTS; i++) begin
        weights[i] <= WEIGHT_DN_RESET;
      end
    end else if (cfg.valid && cfg.ready && (32'(cfg.index) < NUM_WEIGHTS)) begin
      weights[cfg.index] <= WEIGHT_W'(cfg.data);
    end
  end

  assign win_adv       = !win_ctl.valid || win_ready;
  assign samples.ready = win_adv && (flush_cnt == '0);
  assign accept        = samples.valid && samples.ready;
  assign step          = win_adv && (flush_cnt != '0);
  assign load          = accept || step;
  assign fill          = accept && (line_pos == '0);
  assign shift_in      = accept ? samples.sample : window[0];
  assign pos_inc       = (line_pos == POS_W'(DELAY + 1)) ? line_pos : line_pos + 1'b1;

  always_comb begin
    window_next[0] = shift_in;
    for (int i = 1; i < TAPS; i++) begin
      window_next[i] = fill ? samples.sample : window[i-1];
    end
  end

  always_comb begin
    line_pos_next  = line_pos;
    flush_cnt_next = flush_cnt;
    win_ctl_next   = win_ctl;
    if (win_adv) begin
      win_ctl_next = '0;
    end
    if (accept) begin
      win_ctl_next.valid = (pos_inc == POS_W'(DELAY + 1));
      win_ctl_next.last  = 1'b0;
      if (samples.line_end) begin
        line_pos_next  = pos_inc;
        flush_cnt_next = FL_W'(DELAY);
      end else if (pos_inc == POS_W'(DELAY + 1)) begin
        line_pos_next = POS_W'(DELAY);
      end else begin
        line_pos_next = pos_inc;
      end
    end else if (step) begin
      win_ctl_next.valid = (pos_inc == POS_W'(DELAY + 1));
      win_ctl_next.last  = (flush_cnt == FL_W'(1));
      flush_cnt_next     = flush_cnt - 1'b1;
      if (flush_cnt == FL_W'(1)) begin
        line_pos_next = '0;
      end else begin
        line_pos_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos  <= '0;
      flush_cnt <= '0;
      win_ctl   <= '0;
    end else begin
      line_pos  <= line_pos_next;
      flush_cnt <= flush_cnt_next;
      win_ctl   <= win_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window <= window_next;
    end
  end

  lbcf_filter #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .win_ctl  (win_ctl),
    .window   (window),
    .weights  (weights),
    .win_ready(win_ready),
    .results  (results)
  );

`ifndef SYNTHESIS
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready && samples.line_end) |=> (flush_cnt == FL_W'(DELAY)))
    else $error("flush did not start after the last sample of a line");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (win_adv && (flush_cnt == FL_W'(1))) |=> (win_ctl.valid && win_ctl.last && line_pos == '0))
    else $error("final flush shift did not mark the last result");

  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    (win_ctl.valid && !win_ready) |=> (win_ctl.valid && $stable(window[DELAY])))
    else $error("window changed while its result was stalled");
`endif

endmodule
